// File: rtl/pre_pkg.sv
// Shared types and constants for the ping round-trip time estimator.
// Holds the channel item structs and the command passed from front to back.
// No dependencies.
`timescale 1ns / 1ps

package pre_pkg;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 16'd1000;

    // Input item, fields in channel order
    typedef struct packed {
        logic              func;
        logic [TIME_W-1:0] now_ms;
        logic              enable;
        logic [TIME_W-1:0] seq_num;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic              send_request;
        logic [TIME_W-1:0] request_number;
        logic [TIME_W-1:0] last_rtt_ms;
        logic [TIME_W-1:0] avg_rtt_ms;
    } t_out_item;

    // Event class as decided by the front end
    typedef enum logic [1:0] {
        OP_TICK_OFF = 2'd0,
        OP_TICK_EN  = 2'd1,
        OP_RESP     = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] time_ms;
        logic [TIME_W-1:0] number;
    } t_cmd;

endpackage

// File: rtl/ping_rtt_estimator.sv
// Top level of the ping round-trip time estimator.
// Depends on pre_pkg, pre_front, pre_queue and pre_back.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries events: a tick
// (func 0) or a ping response (func 1), each with the current ms time.
// Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly one
// result item per event, in order: send flag, ping number, latest RTT and the
// floor mean of the nonzero RTT samples.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the minimum
// send interval; write it only while no event is in flight.
// Front end registers and classifies an event, then a two-entry queue feeds
// the back end, which takes the next event only after emitting the last. A tick
// or unmatched response goes straight from idle to emit. A matched response also
// walks the sample ring and runs a restoring divider, one quotient bit per cycle
// over the sum width (38 bits at the default depth), before its result is emitted.
// Reset clears the control state, the sample ring reads as empty, and the
// interval returns to 1000 ms. A stalled receiver holds the result register;
// beyond the event held in the back end, front end and queue take three more
// before o_in_stall rises.
`timescale 1ns / 1ps

module ping_rtt_estimator #(
    parameter int SAMPLE_COUNT = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  pre_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output pre_pkg::t_out_item        o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [pre_pkg::CFG_W-1:0] i_cfg_data
);

    pre_pkg::t_cmd front_cmd;
    pre_pkg::t_cmd q_head;
    logic          push;
    logic          q_full;
    logic          q_empty;
    logic          pop;

    // config register is always writable
    assign o_cfg_ready = 1'b1;

    pre_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .i_q_full   (q_full)
    );

    pre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    pre_back #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (q_empty),
        .i_head      (q_head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: rtl/pre_front.sv
// Front end: accepts input items, classifies them and registers one command.
// Depends on pre_pkg.
`timescale 1ns / 1ps

module pre_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pre_pkg::t_in_item i_in_data,
    output logic              o_push,
    output pre_pkg::t_cmd     o_cmd,
    input  logic              i_q_full
);

    logic          r_valid;
    pre_pkg::t_cmd r_cmd;
    pre_pkg::t_cmd n_cmd;
    logic          accept;

    assign o_push     = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd.time_ms = i_in_data.now_ms;
        n_cmd.number  = i_in_data.seq_num;
        if (i_in_data.func) begin
            n_cmd.op = pre_pkg::OP_RESP;
        end else if (i_in_data.enable) begin
            n_cmd.op = pre_pkg::OP_TICK_EN;
        end else begin
            n_cmd.op = pre_pkg::OP_TICK_OFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: rtl/pre_queue.sv
// Two-entry command queue between front end and back end.
// Depends on pre_pkg.
`timescale 1ns / 1ps

module pre_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pre_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output pre_pkg::t_cmd o_head
);

    pre_pkg::t_cmd r_slot [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/pre_back.sv
// Back end: ping state, sample ring, averaging sweep, serial divider, result register.
// Depends on pre_pkg.
`timescale 1ns / 1ps

module pre_back #(
    parameter int SAMPLE_COUNT = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pre_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_q_empty,
    input  pre_pkg::t_cmd                  i_head,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pre_pkg::t_out_item             o_out_data
);

    localparam int TW     = pre_pkg::TIME_W;
    localparam int IDX_W  = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int CNT_W  = $clog2(SAMPLE_COUNT + 1);
    localparam int SUM_W  = (TW + CNT_W > 38) ? (TW + CNT_W) : 38;
    localparam int STEP_W = $clog2(SUM_W + 1);

    localparam logic [IDX_W-1:0]  SLOT_LAST = IDX_W'(SAMPLE_COUNT - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(SAMPLE_COUNT);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SWEEP = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state                   r_state;
    logic [pre_pkg::CFG_W-1:0] r_min_gap;
    logic [TW-1:0]            r_ping_count;
    logic [TW-1:0]            r_send_time;
    logic                     r_awaiting;
    logic [TW-1:0]            r_last_rtt;
    logic [TW-1:0]            r_avg;
    logic                     r_sent;
    logic [IDX_W-1:0]         r_slot;
    logic [SAMPLE_COUNT-1:0]  r_smp_valid;

    // sample ring
    logic [TW-1:0]            r_mem [SAMPLE_COUNT];
    logic [TW-1:0]            r_rd_data;
    logic                     r_rd_ok;
    logic                     r_rd_live;
    logic [CNT_W-1:0]         r_idx;
    logic [SUM_W-1:0]         r_sum;
    logic [CNT_W-1:0]         r_n;

    // divider
    logic [SUM_W-1:0]         r_quo;
    logic [CNT_W-1:0]         r_rem;
    logic [STEP_W-1:0]        r_step;

    logic                     r_out_valid;
    pre_pkg::t_out_item       r_out;

    logic [TW-1:0]            elapsed;
    logic                     tick_go;
    logic                     resp_hit;
    logic                     mem_we;
    logic                     rd_issue;
    logic [IDX_W-1:0]         rd_addr;
    logic [CNT_W:0]           rem_sh;
    logic                     q_bit;
    logic [CNT_W:0]           rem_sub;
    logic                     out_free;

    assign elapsed  = i_head.time_ms - r_send_time;
    assign tick_go  = (i_head.op == pre_pkg::OP_TICK_EN) && !r_awaiting
                      && (elapsed >= {{(TW - pre_pkg::CFG_W){1'b0}}, r_min_gap});
    assign resp_hit = (i_head.op == pre_pkg::OP_RESP) && (i_head.number == r_ping_count);
    assign o_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign mem_we   = o_pop && resp_hit;
    assign rd_issue = (r_state == ST_SWEEP) && (r_idx != CNT_FULL);
    assign rd_addr  = r_idx[IDX_W-1:0];
    assign out_free = !r_out_valid || !i_out_stall;

    // one restoring division step
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_n};
    assign q_bit   = (rem_sh >= {1'b0, r_n});

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot] <= elapsed;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_min_gap    <= pre_pkg::CFG_RESET;
            r_ping_count <= '0;
            r_send_time  <= '0;
            r_awaiting   <= 1'b0;
            r_last_rtt   <= '0;
            r_avg        <= '0;
            r_sent       <= 1'b0;
            r_slot       <= '0;
            r_smp_valid  <= '0;
            r_rd_ok      <= 1'b0;
            r_rd_live    <= 1'b0;
            r_idx        <= '0;
            r_sum        <= '0;
            r_n          <= '0;
            r_quo        <= '0;
            r_rem        <= '0;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_gap <= i_cfg_data;
            end
            // load a new result or drop the one just taken
            if ((r_state == ST_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_sent <= tick_go;
                        if (tick_go) begin
                            r_ping_count <= r_ping_count + TW'(1);
                            r_send_time  <= i_head.time_ms;
                            r_awaiting   <= 1'b1;
                            // slot tracks count mod depth, including the 2^32 wrap
                            if (r_ping_count == '1 || r_slot == SLOT_LAST) begin
                                r_slot <= '0;
                            end else begin
                                r_slot <= r_slot + IDX_W'(1);
                            end
                            r_state <= ST_EMIT;
                        end else if (resp_hit) begin
                            r_last_rtt          <= elapsed;
                            r_smp_valid[r_slot] <= 1'b1;
                            r_awaiting          <= 1'b0;
                            r_idx               <= '0;
                            r_sum               <= '0;
                            r_n                 <= '0;
                            r_rd_live           <= 1'b0;
                            r_state             <= ST_SWEEP;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end
                end

                ST_SWEEP: begin
                    r_rd_live <= rd_issue;
                    r_rd_ok   <= r_smp_valid[rd_addr];
                    if (rd_issue) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (r_rd_live && r_rd_ok && (r_rd_data != '0)) begin
                        r_sum <= r_sum + {{(SUM_W - TW){1'b0}}, r_rd_data};
                        r_n   <= r_n + CNT_W'(1);
                    end
                    if (!rd_issue && !r_rd_live) begin
                        if (r_n == '0) begin
                            r_avg   <= '0;
                            r_state <= ST_EMIT;
                        end else begin
                            r_quo   <= r_sum;
                            r_rem   <= '0;
                            r_step  <= '0;
                            r_state <= ST_DIV;
                        end
                    end
                end

                ST_DIV: begin
                    r_quo <= {r_quo[SUM_W-2:0], q_bit};
                    r_rem <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_LAST) begin
                        // quotient of a mean always fits the time width
                        r_avg   <= {r_quo[TW-2:0], q_bit};
                        r_state <= ST_EMIT;
                    end
                end

                ST_EMIT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && out_free) begin
            r_out.send_request   <= r_sent;
            r_out.request_number <= r_ping_count;
            r_out.last_rtt_ms    <= r_last_rtt;
            r_out.avg_rtt_ms     <= r_avg;
        end
    end

endmodule
